@@ hdl/safq_pkg.sv @@
// ----------------------------------------------------------------------------
// safq_pkg
// shared types and constants of the servo angle frame queue
// ----------------------------------------------------------------------------
package safq_pkg;

    // function codes of an input item
    typedef enum logic [1:0] {
        FN_SET_ANGLE   = 2'd0,
        FN_TX_COMPLETE = 2'd1,
        FN_TX_ERROR    = 2'd2,
        FN_POLL        = 2'd3
    } func_t;

    // status codes of a result
    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_NO_SLOT  = 3'd1,
        STAT_RANGE    = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_EVENT    = 3'd4
    } status_t;

    // configuration register indexes
    localparam logic [2:0] CFG_SLOT0_ADDR   = 3'd0;
    localparam logic [2:0] CFG_SLOT1_ADDR   = 3'd1;
    localparam logic [2:0] CFG_SLOT2_ADDR   = 3'd2;
    localparam logic [2:0] CFG_SLOT_ENABLE  = 3'd3;
    localparam logic [2:0] CFG_MOVE_TIME    = 3'd4;
    localparam logic [2:0] CFG_POWER_LIMIT  = 3'd5;
    localparam logic [2:0] CFG_ANGLE_LIMIT  = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int ADDR_SLOTS  = 3;

    // frame layout
    localparam logic [7:0] FRAME_SYNC0   = 8'h12;
    localparam logic [7:0] FRAME_SYNC1   = 8'h4C;
    localparam logic [7:0] FRAME_CMD     = 8'h08;
    localparam logic [7:0] FRAME_PAY_LEN = 8'h07;
    localparam int         FRAME_LEN     = 12;
    localparam int         BYTE_IDX_W    = 4;

    localparam int ENTRY_W = 24;

    typedef struct packed {
        logic [1:0]         func;
        logic [1:0]         servo_slot;
        logic signed [15:0] angle;
    } cmd_t;

    typedef struct packed {
        logic [2:0] status;
        logic       byte_valid;
        logic [7:0] frame_byte;
        logic       last;
        logic [3:0] queue_count;
        logic       link_busy;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic fetch;
        logic send;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic send_go;
        logic last_byte;
    } dp_stat_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_FETCH = 2'd2,
        S_SEND  = 2'd3
    } ctrl_state_t;

endpackage

@@ hdl/safq_ram.sv @@
// ----------------------------------------------------------------------------
// safq_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module safq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/safq_ctrl.sv @@
// ----------------------------------------------------------------------------
// safq_ctrl
// sequencing of one item: evaluate, fetch head entry, send frame bytes
// ----------------------------------------------------------------------------
module safq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  safq_pkg::dp_stat_t   stat,
    output safq_pkg::ctrl_cmd_t  ctrl
);

    safq_pkg::ctrl_state_t state_reg;
    safq_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= safq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            safq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = safq_pkg::S_EXEC;
                end
            end
            safq_pkg::S_EXEC:
            begin
                state_next = stat.send_go ? safq_pkg::S_FETCH : safq_pkg::S_IDLE;
            end
            safq_pkg::S_FETCH:
            begin
                state_next = safq_pkg::S_SEND;
            end
            safq_pkg::S_SEND:
            begin
                if (stat.last_byte)
                begin
                    state_next = safq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = safq_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl = '0;
        busy = 1'b1;
        case (state_reg)
            safq_pkg::S_IDLE:
            begin
                busy      = 1'b0;
                ctrl.load = start;
            end
            safq_pkg::S_EXEC:
            begin
                ctrl.exec = 1'b1;
            end
            safq_pkg::S_FETCH:
            begin
                ctrl.fetch = 1'b1;
            end
            safq_pkg::S_SEND:
            begin
                ctrl.send = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

@@ hdl/safq_dp.sv @@
// ----------------------------------------------------------------------------
// safq_dp
// config registers, queue pointers, entry ram and frame byte generation
// ----------------------------------------------------------------------------
module safq_dp #(
    parameter int QUEUE_DEPTH = 8,
    parameter int SLOT_COUNT  = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  safq_pkg::cmd_t                      cmd,
    input  safq_pkg::ctrl_cmd_t                 ctrl,
    output safq_pkg::dp_stat_t                  stat,
    input  logic                                cfg_we,
    input  logic [safq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [safq_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                result_valid,
    output safq_pkg::result_t                   result
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [safq_pkg::BYTE_IDX_W-1:0] LAST_BYTE =
        safq_pkg::BYTE_IDX_W'(safq_pkg::FRAME_LEN - 1);

    // configuration
    logic [7:0]  slot0_addr_reg;
    logic [7:0]  slot1_addr_reg;
    logic [7:0]  slot2_addr_reg;
    logic [2:0]  slot_enable_reg;
    logic [15:0] move_time_reg;
    logic [15:0] power_limit_reg;
    logic [14:0] angle_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot0_addr_reg  <= 8'd0;
            slot1_addr_reg  <= 8'd1;
            slot2_addr_reg  <= 8'd2;
            slot_enable_reg <= 3'd0;
            move_time_reg   <= 16'd100;
            power_limit_reg <= 16'd0;
            angle_limit_reg <= 15'd1350;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                safq_pkg::CFG_SLOT0_ADDR:  slot0_addr_reg  <= cfg_data[7:0];
                safq_pkg::CFG_SLOT1_ADDR:  slot1_addr_reg  <= cfg_data[7:0];
                safq_pkg::CFG_SLOT2_ADDR:  slot2_addr_reg  <= cfg_data[7:0];
                safq_pkg::CFG_SLOT_ENABLE: slot_enable_reg <= cfg_data[2:0];
                safq_pkg::CFG_MOVE_TIME:   move_time_reg   <= cfg_data;
                safq_pkg::CFG_POWER_LIMIT: power_limit_reg <= cfg_data;
                safq_pkg::CFG_ANGLE_LIMIT: angle_limit_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // captured item
    safq_pkg::cmd_t cmd_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd;
        end
    end

    // queue state
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             sending_reg;
    logic             sending_next;
    logic [2:0]       status_reg;
    logic [2:0]       status_next;

    // item evaluation
    logic               is_set;
    logic               is_cmp;
    logic               is_err;
    logic               slot_en;
    logic [7:0]         slot_addr;
    logic signed [16:0] ang_ext;
    logic signed [16:0] lim_pos;
    logic signed [16:0] lim_neg;
    logic [2:0]         status_c;
    logic               push;
    logic               pop;
    logic [CNT_W-1:0]   count_after;
    logic               sending_after;
    logic               send_go;

    always_comb
    begin
        is_set = (cmd_reg.func == safq_pkg::FN_SET_ANGLE);
        is_cmp = (cmd_reg.func == safq_pkg::FN_TX_COMPLETE);
        is_err = (cmd_reg.func == safq_pkg::FN_TX_ERROR);

        case (cmd_reg.servo_slot)
            2'd0:
            begin
                slot_en   = slot_enable_reg[0];
                slot_addr = slot0_addr_reg;
            end
            2'd1:
            begin
                slot_en   = slot_enable_reg[1];
                slot_addr = slot1_addr_reg;
            end
            2'd2:
            begin
                slot_en   = slot_enable_reg[2];
                slot_addr = slot2_addr_reg;
            end
            default:
            begin
                slot_en   = 1'b0;
                slot_addr = 8'd0;
            end
        endcase
        if (int'(cmd_reg.servo_slot) >= SLOT_COUNT)
        begin
            slot_en = 1'b0;
        end

        ang_ext = {cmd_reg.angle[15], cmd_reg.angle};
        lim_pos = signed'({2'b00, angle_limit_reg});
        lim_neg = 17'sd0 - lim_pos;

        if (!is_set)
        begin
            status_c = safq_pkg::STAT_EVENT;
        end
        else if (!slot_en)
        begin
            status_c = safq_pkg::STAT_NO_SLOT;
        end
        else if (ang_ext > lim_pos || ang_ext < lim_neg)
        begin
            status_c = safq_pkg::STAT_RANGE;
        end
        else if (count_reg == FULL_CNT)
        begin
            status_c = safq_pkg::STAT_FULL;
        end
        else
        begin
            status_c = safq_pkg::STAT_OK;
        end

        push = is_set && (status_c == safq_pkg::STAT_OK);
        pop  = is_cmp && (count_reg != '0);

        if (push)
        begin
            count_after = count_reg + CNT_W'(1);
        end
        else if (pop)
        begin
            count_after = count_reg - CNT_W'(1);
        end
        else
        begin
            count_after = count_reg;
        end

        sending_after = (is_cmp || is_err) ? 1'b0 : sending_reg;

        send_go = !is_err && !(is_set && status_c != safq_pkg::STAT_OK)
                  && !sending_after && (count_after != '0);
    end

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        sending_next = sending_reg;
        status_next  = status_reg;
        if (ctrl.exec)
        begin
            if (push)
            begin
                tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + IDX_W'(1);
            end
            if (pop)
            begin
                head_next = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
            end
            count_next   = count_after;
            sending_next = send_go ? 1'b1 : sending_after;
            status_next  = status_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            sending_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            sending_reg <= sending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    // entry store: address over angle
    logic [safq_pkg::ENTRY_W-1:0] entry_rd;

    safq_ram #(
        .WIDTH (safq_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ctrl.exec && push),
        .waddr (tail_reg),
        .wdata ({slot_addr, cmd_reg.angle}),
        .raddr (head_reg),
        .rdata (entry_rd)
    );

    // frame byte sequencing with running checksum
    logic [safq_pkg::BYTE_IDX_W-1:0] byte_idx_reg;
    logic [7:0]                      sum_reg;
    logic [7:0]                      frame_byte;
    logic                            last_byte;

    always_comb
    begin
        case (byte_idx_reg)
            4'd0:    frame_byte = safq_pkg::FRAME_SYNC0;
            4'd1:    frame_byte = safq_pkg::FRAME_SYNC1;
            4'd2:    frame_byte = safq_pkg::FRAME_CMD;
            4'd3:    frame_byte = safq_pkg::FRAME_PAY_LEN;
            4'd4:    frame_byte = entry_rd[23:16];
            4'd5:    frame_byte = entry_rd[7:0];
            4'd6:    frame_byte = entry_rd[15:8];
            4'd7:    frame_byte = move_time_reg[7:0];
            4'd8:    frame_byte = move_time_reg[15:8];
            4'd9:    frame_byte = power_limit_reg[7:0];
            4'd10:   frame_byte = power_limit_reg[15:8];
            4'd11:   frame_byte = sum_reg;
            default: frame_byte = 8'd0;
        endcase
        last_byte = (byte_idx_reg == LAST_BYTE);
    end

    assign stat = '{send_go: send_go, last_byte: last_byte};

    always_ff @(posedge clk)
    begin
        if (ctrl.fetch)
        begin
            byte_idx_reg <= '0;
            sum_reg      <= 8'd0;
        end
        else if (ctrl.send)
        begin
            byte_idx_reg <= byte_idx_reg + safq_pkg::BYTE_IDX_W'(1);
            sum_reg      <= sum_reg + frame_byte;
        end
    end

    // result register
    logic              result_valid_reg;
    logic              result_valid_next;
    safq_pkg::result_t result_reg;
    safq_pkg::result_t result_next;

    always_comb
    begin
        result_valid_next = 1'b0;
        result_next       = result_reg;
        if (ctrl.exec && !send_go)
        begin
            result_valid_next       = 1'b1;
            result_next.status      = status_c;
            result_next.byte_valid  = 1'b0;
            result_next.frame_byte  = 8'd0;
            result_next.last        = 1'b1;
            result_next.queue_count = 4'(count_after);
            result_next.link_busy   = sending_after;
        end
        else if (ctrl.send)
        begin
            result_valid_next       = 1'b1;
            result_next.status      = status_reg;
            result_next.byte_valid  = 1'b1;
            result_next.frame_byte  = frame_byte;
            result_next.last        = last_byte;
            result_next.queue_count = 4'(count_reg);
            result_next.link_busy   = sending_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ hdl/servo_angle_frame_queue.sv @@
// ----------------------------------------------------------------------------
// servo_angle_frame_queue
// queues servo angle commands and emits 12-byte command frames for a serial
// link; link events pop, release or resend the head frame
// ----------------------------------------------------------------------------
//
//  channel   ports                                   transfer when
//  --------  --------------------------------------  ---------------------------
//  command   start, busy, cmd                        start high, busy low
//  result    result_valid, result                    result_valid high (1 cycle)
//  config    cfg_we, cfg_index, cfg_data             cfg_we high
//
//  an item with a single result: evaluate cycle after the command transfer,
//  result in the next cycle; busy is high for the evaluate cycle only, so
//  the next command can be taken as soon as the block is back in idle
//  an item that starts a frame: evaluate, a ram read for the head
//  entry, then the twelve frame bytes; a new command is taken only after
//  the last byte, the byte run itself streams one byte per cycle
//  the checksum is built serially while the bytes go out
//  reset clears the queue pointers and link flag, presets the config registers
//  the receiver cannot stall: every result is shown for exactly one cycle
//
module servo_angle_frame_queue #(
    parameter int QUEUE_DEPTH = 8,
    parameter int SLOT_COUNT  = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  safq_pkg::cmd_t                      cmd,
    // result channel
    output logic                                result_valid,
    output safq_pkg::result_t                   result,
    // configuration port
    input  logic                                cfg_we,
    input  logic [safq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [safq_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // command and status between sequencer and datapath
    safq_pkg::ctrl_cmd_t ctrl;
    safq_pkg::dp_stat_t  stat;

    // sequencer: idle, evaluate, head fetch, byte run
    safq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    // datapath: checks, ring pointers, entry ram, frame bytes
    safq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SLOT_COUNT  (SLOT_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .ctrl         (ctrl),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // an accepted command keeps the block busy in the next cycle
    a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after command transfer");

    // a result without a frame byte is always the only and last one
    a_plain_last : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.byte_valid |-> result.last)
        else $error("plain result without last");

    // a byte run continues without gaps until its last byte
    a_run_gapless : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.byte_valid && !result.last
        |=> result_valid && result.byte_valid)
        else $error("gap in frame byte run");

    // frame bytes only while the link is marked busy
    a_run_link_busy : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.byte_valid |-> result.link_busy)
        else $error("frame byte while link idle");

    // no command transfer while bytes are still coming
    a_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.send |-> busy)
        else $error("command window open during byte run");

endmodule

@@ test/tb_servo_angle_frame_queue.sv @@
// ----------------------------------------------------------------------------
// tb_servo_angle_frame_queue
// self-checking bench for the servo angle frame queue: a directed table covers
// reset values, slot and angle rejects, a full ring and the link events, then
// random command mixes run under several register settings and sender gaps;
// every result strobe is compared field by field with an in-bench predictor
// ----------------------------------------------------------------------------
module tb_servo_angle_frame_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH   = 8;
    localparam int RESET_ROWS   = 4;     // table rows run with reset settings
    localparam int PHASE_ITEMS  = 82;    // random commands per phase
    localparam int PHASES       = 4;
    localparam int MAX_GAP      = 40;    // longest sender pause in cycles
    localparam int STALL_LIMIT  = 1000;  // cycles without any transfer
    localparam int DRAIN_CYCLES = 20;

    // dut signals
    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic                             busy;
    safq_pkg::cmd_t                   cmd;
    logic                             result_valid;
    safq_pkg::result_t                result;
    logic                             cfg_we;
    logic [safq_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [safq_pkg::CFG_DATA_W-1:0]  cfg_data;

    // predictor copy of the registers
    logic [7:0]  addr_of_slot [safq_pkg::ADDR_SLOTS];
    logic [2:0]  enabled_slots;
    logic [15:0] move_ms;
    logic [15:0] power_mw;
    logic [14:0] max_angle;

    // predictor copy of the frame ring and link flag
    logic [23:0] ring_entry [RING_DEPTH];
    logic [2:0]  ring_head;
    logic [2:0]  ring_tail;
    logic [3:0]  ring_fill;
    logic        link_on;

    // results still owed by the dut, oldest first
    safq_pkg::result_t due_results [$];

    // run statistics
    int mismatches;
    int items_sent;
    int results_checked;
    int frames_seen;
    int rejects_seen;
    int idle_cycles;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct {
        safq_pkg::cmd_t    c;
        bit                typed;
        safq_pkg::status_t st;
        logic [3:0]        qc;
        logic              lb;
    } row_t;

    row_t plan [$];

    servo_angle_frame_queue #(
        .QUEUE_DEPTH (RING_DEPTH),
        .SLOT_COUNT  (safq_pkg::ADDR_SLOTS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // queue one expected result; count and link flag are taken after the update
    function automatic void push_due(input safq_pkg::status_t st, input logic v,
                                     input logic [7:0] b, input logic l);
        safq_pkg::result_t r;
        r.status      = st;
        r.byte_valid  = v;
        r.frame_byte  = b;
        r.last        = l;
        r.queue_count = ring_fill;
        r.link_busy   = link_on;
        due_results.push_back(r);
    endfunction

    // advance the ring for one command and queue the results it causes
    function automatic void servo_queue_step(input safq_pkg::cmd_t c);
        safq_pkg::status_t st;
        int                ang;
        int                lim;
        logic [7:0]        frame [safq_pkg::FRAME_LEN];
        logic [7:0]        sum;
        logic [23:0]       e;
        st  = safq_pkg::STAT_EVENT;
        ang = int'(c.angle);
        lim = int'(max_angle);
        case (c.func)
            safq_pkg::FN_SET_ANGLE:
            begin
                // slot check first, then angle, then room in the ring
                if (c.servo_slot >= safq_pkg::ADDR_SLOTS || !enabled_slots[c.servo_slot])
                    st = safq_pkg::STAT_NO_SLOT;
                else if (ang > lim || ang < -lim)
                    st = safq_pkg::STAT_RANGE;
                else if (ring_fill >= RING_DEPTH)
                    st = safq_pkg::STAT_FULL;
                else
                begin
                    st = safq_pkg::STAT_OK;
                    ring_entry[ring_tail] = {addr_of_slot[c.servo_slot], c.angle};
                    ring_tail++;
                    ring_fill++;
                end
                if (st != safq_pkg::STAT_OK)
                begin
                    push_due(st, 1'b0, 8'h00, 1'b1);
                    return;
                end
            end
            safq_pkg::FN_TX_COMPLETE:
            begin
                // pops even when the link was idle
                link_on = 1'b0;
                if (ring_fill != 0)
                begin
                    ring_head++;
                    ring_fill--;
                end
            end
            safq_pkg::FN_TX_ERROR:
            begin
                // head stays; the link restarts with the next command that is not a reject or another error
                link_on = 1'b0;
                push_due(st, 1'b0, 8'h00, 1'b1);
                return;
            end
            default: ;
        endcase
        if (link_on || ring_fill == 0)
        begin
            push_due(st, 1'b0, 8'h00, 1'b1);
            return;
        end
        // head frame goes out; time and power come from the registers now
        e         = ring_entry[ring_head];
        frame[0]  = safq_pkg::FRAME_SYNC0;
        frame[1]  = safq_pkg::FRAME_SYNC1;
        frame[2]  = safq_pkg::FRAME_CMD;
        frame[3]  = safq_pkg::FRAME_PAY_LEN;
        frame[4]  = e[23:16];
        frame[5]  = e[7:0];
        frame[6]  = e[15:8];
        frame[7]  = move_ms[7:0];
        frame[8]  = move_ms[15:8];
        frame[9]  = power_mw[7:0];
        frame[10] = power_mw[15:8];
        sum = 8'h00;
        for (int i = 0; i < safq_pkg::FRAME_LEN - 1; i++)
            sum += frame[i];
        frame[safq_pkg::FRAME_LEN-1] = sum;
        link_on = 1'b1;
        for (int i = 0; i < safq_pkg::FRAME_LEN; i++)
            push_due(st, 1'b1, frame[i], i == safq_pkg::FRAME_LEN - 1);
    endfunction

    function automatic void add_row(input safq_pkg::func_t f, input logic [1:0] s,
                                    input int a, input bit typed,
                                    input safq_pkg::status_t st,
                                    input logic [3:0] qc, input logic lb);
        row_t r;
        r.c.func       = f;
        r.c.servo_slot = s;
        r.c.angle      = a[15:0];
        r.typed        = typed;
        r.st           = st;
        r.qc           = qc;
        r.lb           = lb;
        plan.push_back(r);
    endfunction

    // present a command and hold it until the transfer; start is left high
    task automatic send_cmd(input safq_pkg::cmd_t c);
        cmd   <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        servo_queue_step(c);
        items_sent++;
    endtask

    // register write, one per cycle; cfg_we is left high for the caller
    task automatic cfg_write(input logic [safq_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [safq_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            safq_pkg::CFG_SLOT0_ADDR:  addr_of_slot[0] = data[7:0];
            safq_pkg::CFG_SLOT1_ADDR:  addr_of_slot[1] = data[7:0];
            safq_pkg::CFG_SLOT2_ADDR:  addr_of_slot[2] = data[7:0];
            safq_pkg::CFG_SLOT_ENABLE: enabled_slots   = data[2:0];
            safq_pkg::CFG_MOVE_TIME:   move_ms         = data;
            safq_pkg::CFG_POWER_LIMIT: power_mw        = data;
            safq_pkg::CFG_ANGLE_LIMIT: max_angle       = data[14:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [7:0] a0, input logic [7:0] a1,
                               input logic [7:0] a2, input logic [2:0] mask,
                               input logic [15:0] mt, input logic [15:0] pw,
                               input logic [14:0] lim);
        cfg_write(safq_pkg::CFG_SLOT0_ADDR, {8'h00, a0});
        cfg_write(safq_pkg::CFG_SLOT1_ADDR, {8'h00, a1});
        cfg_write(safq_pkg::CFG_SLOT2_ADDR, {8'h00, a2});
        cfg_write(safq_pkg::CFG_SLOT_ENABLE, {13'h0000, mask});
        cfg_write(safq_pkg::CFG_MOVE_TIME, mt);
        cfg_write(safq_pkg::CFG_POWER_LIMIT, pw);
        cfg_write(safq_pkg::CFG_ANGLE_LIMIT, {1'b0, lim});
        cfg_we <= 1'b0;
    endtask

    // hold off the sender until every owed result has come and busy is low
    task automatic wait_idle;
        start <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0 || busy)
            @(posedge clk);
        repeat (3)
            @(posedge clk);
    endtask

    // sender pause: each cycle idle with the given percentage
    task automatic idle_gap(input int pct);
        int n;
        n = 0;
        while (n < MAX_GAP && $urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            n++;
        end
    endtask

    // result checker: every strobe is matched against the oldest owed result
    always @(posedge clk)
    begin
        safq_pkg::result_t want;
        if (rst_n && result_valid)
        begin
            results_checked++;
            if (result.byte_valid && result.last)
                frames_seen++;
            if (result.status == safq_pkg::STAT_NO_SLOT
                    || result.status == safq_pkg::STAT_RANGE
                    || result.status == safq_pkg::STAT_FULL)
                rejects_seen++;
            if (due_results.size() == 0)
                report_mismatch("result with nothing due, status",
                                int'(result.status), 0);
            else
            begin
                want = due_results.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", int'(result.status),
                                    int'(want.status));
                if (result.byte_valid !== want.byte_valid)
                    report_mismatch("byte_valid", int'(result.byte_valid),
                                    int'(want.byte_valid));
                if (result.frame_byte !== want.frame_byte)
                    report_mismatch("frame_byte", int'(result.frame_byte),
                                    int'(want.frame_byte));
                if (result.last !== want.last)
                    report_mismatch("last", int'(result.last), int'(want.last));
                if (result.queue_count !== want.queue_count)
                    report_mismatch("queue_count", int'(result.queue_count),
                                    int'(want.queue_count));
                if (result.link_busy !== want.link_busy)
                    report_mismatch("link_busy", int'(result.link_busy),
                                    int'(want.link_busy));
            end
        end
    end

    // watchdog: any command or result transfer restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        safq_pkg::cmd_t c;
        row_t           row;
        int             r;
        int             pct;
        int             lim;

        // every dut input known from time zero
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        // predictor in its reset state
        for (int s = 0; s < safq_pkg::ADDR_SLOTS; s++)
            addr_of_slot[s] = s[7:0];
        enabled_slots   = 3'b000;
        move_ms         = 16'd100;
        power_mw        = 16'd0;
        max_angle       = 15'd1350;
        for (int k = 0; k < RING_DEPTH; k++)
            ring_entry[k] = '0;
        ring_head       = '0;
        ring_tail       = '0;
        ring_fill       = '0;
        link_on         = 1'b0;
        mismatches      = 0;
        items_sent      = 0;
        results_checked = 0;
        frames_seen     = 0;
        rejects_seen    = 0;
        idle_cycles     = 0;

        // directed table
        // reset settings: no slot registered, events on an empty ring
        add_row(safq_pkg::FN_SET_ANGLE,   2'd0, 0, 1, safq_pkg::STAT_NO_SLOT, 4'd0, 1'b0);
        add_row(safq_pkg::FN_TX_COMPLETE, 2'd0, 0, 1, safq_pkg::STAT_EVENT,   4'd0, 1'b0);
        add_row(safq_pkg::FN_TX_ERROR,    2'd0, 0, 1, safq_pkg::STAT_EVENT,   4'd0, 1'b0);
        add_row(safq_pkg::FN_POLL,        2'd0, 0, 1, safq_pkg::STAT_EVENT,   4'd0, 1'b0);
        // slots 0 and 1 registered, limit 1350: rejects in check order
        add_row(safq_pkg::FN_SET_ANGLE, 2'd3, 0,      1, safq_pkg::STAT_NO_SLOT, 4'd0, 1'b0);
        add_row(safq_pkg::FN_SET_ANGLE, 2'd2, 0,      1, safq_pkg::STAT_NO_SLOT, 4'd0, 1'b0);
        add_row(safq_pkg::FN_SET_ANGLE, 2'd0, 1351,   1, safq_pkg::STAT_RANGE,   4'd0, 1'b0);
        add_row(safq_pkg::FN_SET_ANGLE, 2'd1, -1351,  1, safq_pkg::STAT_RANGE,   4'd0, 1'b0);
        add_row(safq_pkg::FN_SET_ANGLE, 2'd0, 32767,  1, safq_pkg::STAT_RANGE,   4'd0, 1'b0);
        add_row(safq_pkg::FN_SET_ANGLE, 2'd0, -32768, 1, safq_pkg::STAT_RANGE,   4'd0, 1'b0);
        // limits accepted; first one starts a frame, the rest fill the ring
        add_row(safq_pkg::FN_SET_ANGLE, 2'd0, 1350,  0, safq_pkg::STAT_OK, 4'd0, 1'b0);
        add_row(safq_pkg::FN_SET_ANGLE, 2'd1, -1350, 0, safq_pkg::STAT_OK, 4'd0, 1'b0);
        add_row(safq_pkg::FN_SET_ANGLE, 2'd0, 0,     0, safq_pkg::STAT_OK, 4'd0, 1'b0);
        add_row(safq_pkg::FN_SET_ANGLE, 2'd1, 1,     0, safq_pkg::STAT_OK, 4'd0, 1'b0);
        add_row(safq_pkg::FN_SET_ANGLE, 2'd0, -1,    0, safq_pkg::STAT_OK, 4'd0, 1'b0);
        add_row(safq_pkg::FN_SET_ANGLE, 2'd1, 257,   0, safq_pkg::STAT_OK, 4'd0, 1'b0);
        add_row(safq_pkg::FN_SET_ANGLE, 2'd0, -257,  0, safq_pkg::STAT_OK, 4'd0, 1'b0);
        add_row(safq_pkg::FN_SET_ANGLE, 2'd1, 1000,  0, safq_pkg::STAT_OK, 4'd0, 1'b0);
        // ring full, then error, resend by poll, pop from idle link
        add_row(safq_pkg::FN_SET_ANGLE,   2'd0, 5, 1, safq_pkg::STAT_FULL,  4'd8, 1'b1);
        add_row(safq_pkg::FN_TX_ERROR,    2'd1, 0, 1, safq_pkg::STAT_EVENT, 4'd8, 1'b0);
        add_row(safq_pkg::FN_POLL,        2'd2, 0, 0, safq_pkg::STAT_EVENT, 4'd0, 1'b0);
        add_row(safq_pkg::FN_TX_ERROR,    2'd3, 0, 1, safq_pkg::STAT_EVENT, 4'd8, 1'b0);
        add_row(safq_pkg::FN_TX_COMPLETE, 2'd0, 0, 0, safq_pkg::STAT_EVENT, 4'd0, 1'b0);
        add_row(safq_pkg::FN_POLL,        2'd0, 0, 0, safq_pkg::STAT_EVENT, 4'd0, 1'b0);

        // reset held from time zero, released once
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (i == RESET_ROWS)
            begin
                wait_idle();
                load_config(8'hFF, 8'h00, 8'h5A, 3'b011, 16'hFFFF, 16'h0000, 15'd1350);
                @(posedge clk);
            end
            row = plan[i];
            send_cmd(row.c);
            if (row.typed)
            begin
                // swap in the hand-written expectation for this single result
                void'(due_results.pop_back());
                due_results.push_back('{status: row.st, byte_valid: 1'b0,
                                        frame_byte: 8'h00, last: 1'b1,
                                        queue_count: row.qc, link_busy: row.lb});
            end
        end

        // random phases: settings change only with the block idle
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                0: load_config(8'($urandom), 8'($urandom), 8'($urandom), 3'b111,
                               16'($urandom), 16'($urandom), 15'd1350);
                1: load_config(8'($urandom), 8'($urandom), 8'($urandom), 3'b101,
                               16'h0000, 16'hFFFF, 15'd0);
                2: load_config(8'hFF, 8'hFF, 8'hFF, 3'b111,
                               16'($urandom), 16'($urandom), 15'h7FFF);
                default: load_config(8'h00, 8'($urandom), 8'($urandom), 3'b110,
                                     16'($urandom), 16'($urandom),
                                     15'($urandom_range(3000)));
            endcase
            @(posedge clk);
            // sender idle share: none, heavy, light, none
            pct = (p == 1) ? 69 : (p == 2) ? 26 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // mid-phase hold-off until no result is owed and busy is low
                if (n == PHASE_ITEMS / 2)
                    wait_idle();
                r            = $urandom_range(99);
                c.servo_slot = 2'($urandom_range(3));
                c.angle      = 16'($urandom);
                if (r < 48)
                begin
                    c.func = safq_pkg::FN_SET_ANGLE;
                    // mostly registered slots and angles inside the limit
                    if ($urandom_range(99) < 80)
                    begin
                        while (c.servo_slot == 2'd3 || !enabled_slots[c.servo_slot])
                            c.servo_slot = 2'($urandom_range(2));
                        lim     = int'(max_angle);
                        c.angle = 16'($urandom_range(2 * lim) - lim);
                    end
                end
                else if (r < 78)
                    c.func = safq_pkg::FN_TX_COMPLETE;
                else if (r < 88)
                    c.func = safq_pkg::FN_TX_ERROR;
                else
                    c.func = safq_pkg::FN_POLL;
                idle_gap(pct);
                send_cmd(c);
            end
        end

        // drain, then a further wait for anything stray
        wait_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("covered %0d commands, %0d frames and %0d rejected commands",
                 items_sent, frames_seen, rejects_seen);
        $display("%0d results checked with %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && due_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
hdl/safq_pkg.sv
hdl/safq_ram.sv
hdl/safq_ctrl.sv
hdl/safq_dp.sv
hdl/servo_angle_frame_queue.sv
test/tb_servo_angle_frame_queue.sv
